// ===== design/gft_pkg.sv =====
package gft_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_NOFIX  = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_HOLD   = 2'd3
  } fix_mode_t;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_PACKET = 1'b1
  } op_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPOCH      = 1'b0,
    REG_BASE_MONTH = 1'b1
  } cfg_reg_t;

  localparam logic [31:0] EPOCH_RESET      = 32'd1754006400;
  localparam logic [3:0]  BASE_MONTH_RESET = 4'd8;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // ms / 1000 == (ms * MS_RECIP) >> MS_SHIFT for every 16-bit ms
  localparam logic [16:0] MS_RECIP = 17'd67109;
  localparam int          MS_SHIFT = 26;

  // fixed 28-day February; month numbers with no meaning count zero days
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/gft_stream_if.sv =====
interface gft_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        fix_valid;
  logic        position_hold;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [15:0] milliseconds;
  logic [31:0] capture_count;

  modport source (
    output valid, operation, fix_valid, position_hold, month, day_of_month,
           hour, minute, milliseconds, capture_count,
    input  ready
  );
  modport sink (
    input  valid, operation, fix_valid, position_hold, month, day_of_month,
           hour, minute, milliseconds, capture_count,
    output ready
  );
endinterface

interface gft_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fix_mode;
  logic        position_ready;
  logic        hold_heartbeat;
  logic [31:0] utc_seconds;
  logic [31:0] tick_offset;

  modport source (
    output valid, fix_mode, position_ready, hold_heartbeat, utc_seconds, tick_offset,
    input  ready
  );
  modport sink (
    input  valid, fix_mode, position_ready, hold_heartbeat, utc_seconds, tick_offset,
    output ready
  );
endinterface

// ===== design/gnss_fix_tracker_and_packet_timestamper_top.sv =====
// Packets, and reports outside hold mode, give a registered result in the cycle after accept.
// A report in hold mode first sums months from base_month (at most 15 of them), one month per
// cycle through the day counter, then adds the day of month, then runs 5 steps through the
// shared multiplier and 32-bit accumulator. One item at a time; the next is taken once the
// block is idle and the result register is free. Reset (rst, synchronous, active high): init
// mode, timestamp and epoch at 1754006400, base month 8, PPS capture 0, no result pending.
module gnss_fix_tracker_and_packet_timestamper_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gft_pkg::CFG_DATA_W-1:0] cfg_data,
  gft_item_if.sink                       item,
  gft_result_if.source                   result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MON,
    S_DAY,
    S_MUL
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'd4;

  state_t            state;
  gft_pkg::fix_mode_t mode_reg;
  logic [31:0]       epoch_seconds;
  logic [3:0]        base_month;
  logic [31:0]       timestamp_reg;
  logic [31:0]       pps_capture_reg;

  logic [3:0]        mon;
  logic [4:0]        day;
  logic [4:0]        hr;
  logic [5:0]        mn;
  logic [15:0]       ms;
  logic [3:0]        m_cnt;
  logic signed [9:0] days;
  logic [2:0]        step;
  logic [31:0]       prod;
  logic [31:0]       acc;

  logic              o_valid;
  logic [1:0]        o_mode;
  logic              o_ready;
  logic              o_beat;
  logic [31:0]       o_utc;
  logic [31:0]       o_off;

  logic [31:0]       mul_a;
  logic [16:0]       mul_b;
  logic [48:0]       mul_full;
  logic [31:0]       prod_next;
  logic [31:0]       acc_sum;
  logic              take;

  assign item.ready = (state == S_IDLE) && (!o_valid || result.ready);
  assign take       = item.valid && item.ready;

  always_comb begin
    unique case (step)
      3'd0: begin
        mul_a = 32'(days);
        mul_b = gft_pkg::SECS_PER_DAY;
      end
      3'd1: begin
        mul_a = 32'(hr);
        mul_b = gft_pkg::SECS_PER_HOUR;
      end
      3'd2: begin
        mul_a = 32'(mn);
        mul_b = gft_pkg::SECS_PER_MIN;
      end
      3'd3: begin
        mul_a = 32'(ms);
        mul_b = gft_pkg::MS_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full  = 49'(mul_a) * 49'(mul_b);
  assign prod_next = (step == 3'd3) ?
                     32'(mul_full[gft_pkg::MS_SHIFT+15:gft_pkg::MS_SHIFT]) :
                     mul_full[31:0];
  assign acc_sum   = acc + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      mode_reg        <= gft_pkg::MODE_INIT;
      epoch_seconds   <= gft_pkg::EPOCH_RESET;
      base_month      <= gft_pkg::BASE_MONTH_RESET;
      timestamp_reg   <= gft_pkg::EPOCH_RESET;
      pps_capture_reg <= '0;
      o_valid         <= 1'b0;
      step            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (gft_pkg::cfg_reg_t'(cfg_index))
          gft_pkg::REG_EPOCH:      epoch_seconds <= cfg_data;
          gft_pkg::REG_BASE_MONTH: base_month    <= cfg_data[3:0];
        endcase
      end

      if (result.valid && result.ready && !take) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take) begin
            mon   <= item.month;
            day   <= item.day_of_month;
            hr    <= item.hour;
            mn    <= item.minute;
            ms    <= item.milliseconds;
            m_cnt <= base_month;
            days  <= '0;
            acc   <= epoch_seconds;
            step  <= '0;
            if (gft_pkg::op_t'(item.operation) == gft_pkg::OP_PACKET) begin
              o_valid <= 1'b1;
              o_mode  <= mode_reg;
              o_ready <= 1'b0;
              o_beat  <= 1'b0;
              o_utc   <= timestamp_reg;
              o_off   <= item.capture_count - pps_capture_reg;
            end else begin
              pps_capture_reg <= item.capture_count;
              o_utc   <= timestamp_reg;
              o_off   <= '0;
              unique case (mode_reg)
                gft_pkg::MODE_INIT: begin
                  mode_reg <= item.fix_valid ? gft_pkg::MODE_SAMPLE : gft_pkg::MODE_NOFIX;
                  o_mode   <= item.fix_valid ? gft_pkg::MODE_SAMPLE : gft_pkg::MODE_NOFIX;
                  o_ready  <= 1'b0;
                  o_beat   <= 1'b0;
                  o_valid  <= 1'b1;
                end
                gft_pkg::MODE_NOFIX: begin
                  mode_reg <= item.fix_valid ? gft_pkg::MODE_SAMPLE : gft_pkg::MODE_NOFIX;
                  o_mode   <= item.fix_valid ? gft_pkg::MODE_SAMPLE : gft_pkg::MODE_NOFIX;
                  o_ready  <= 1'b0;
                  o_beat   <= 1'b0;
                  o_valid  <= 1'b1;
                end
                gft_pkg::MODE_SAMPLE: begin
                  mode_reg <= item.position_hold ? gft_pkg::MODE_HOLD : gft_pkg::MODE_SAMPLE;
                  o_mode   <= item.position_hold ? gft_pkg::MODE_HOLD : gft_pkg::MODE_SAMPLE;
                  o_ready  <= item.position_hold;
                  o_beat   <= 1'b0;
                  o_valid  <= 1'b1;
                end
                gft_pkg::MODE_HOLD: begin
                  o_mode  <= gft_pkg::MODE_HOLD;
                  o_ready <= 1'b0;
                  o_beat  <= 1'b1;
                  o_valid <= 1'b0;
                  state   <= S_MON;
                end
              endcase
            end
          end
        end
        S_MON: begin
          if (m_cnt < mon) begin
            days  <= days + 10'(gft_pkg::month_len(m_cnt));
            m_cnt <= m_cnt + 4'd1;
          end else begin
            state <= S_DAY;
          end
        end
        S_DAY: begin
          days  <= days + 10'(day) - 10'sd1;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod_next;
          if (step != 3'd0) begin
            acc <= acc_sum;
          end
          if (step == LAST_STEP) begin
            timestamp_reg <= acc_sum;
            o_utc         <= acc_sum;
            o_valid       <= 1'b1;
            state         <= S_IDLE;
          end else begin
            step <= step + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = o_valid;
  assign result.fix_mode       = o_mode;
  assign result.position_ready = o_ready;
  assign result.hold_heartbeat = o_beat;
  assign result.utc_seconds    = o_utc;
  assign result.tick_offset    = o_off;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !item.ready)
    else $error("input taken while a timestamp is being built");

  a_hold_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode_reg == gft_pkg::MODE_HOLD) |=> (mode_reg == gft_pkg::MODE_HOLD))
    else $error("hold mode left without reset");

  a_flags_in_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_ready || o_beat)) |-> (o_mode == gft_pkg::MODE_HOLD && o_off == '0))
    else $error("hold flag on a result that is not a hold report");

  a_ts_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    !(state == S_MUL && step == LAST_STEP) |=> $stable(timestamp_reg))
    else $error("timestamp changed outside the build sequence");

endmodule
